>>> rtl/mfrr_pkg.sv
// Package for the median frame-rate regulator.
// Holds field widths, register reset values, codes and the sequencer state type.
// No dependencies.
`default_nettype none

package mfrr_pkg;

  localparam int unsigned RATE_BITS = 10;
  localparam int unsigned AGE_BITS  = 8;
  localparam int unsigned ACT_BITS  = 5;
  localparam int unsigned IDX_BITS  = 2;
  localparam int unsigned CFG_BITS  = 10;

  localparam logic [RATE_BITS-1:0] RATE_MAX  = {RATE_BITS{1'b1}};
  localparam logic [RATE_BITS-1:0] STEP_CAP  = RATE_BITS'(10);
  localparam logic [RATE_BITS-1:0] RATE_ONE  = RATE_BITS'(1);
  localparam logic [AGE_BITS-1:0]  AGE_MAX   = {AGE_BITS{1'b1}};

  localparam logic [RATE_BITS-1:0] TARGET_RST = RATE_BITS'(60);
  localparam logic [AGE_BITS-1:0]  WARMUP_RST = AGE_BITS'(2);
  localparam logic [ACT_BITS-1:0]  ACT_RST    = ACT_BITS'(5);
  localparam logic [RATE_BITS-1:0] INIT_RST   = RATE_BITS'(60);

  typedef enum logic [IDX_BITS-1:0] {
    REG_TARGET = 2'd0,
    REG_WARMUP = 2'd1,
    REG_ACT    = 2'd2,
    REG_INIT   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_SAMPLE  = 1'b0,
    KIND_RESTART = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_CAND_RD,
    ST_CAND_LD,
    ST_CMP,
    ST_EVAL,
    ST_ADJ,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

>>> rtl/mfrr_if.sv
// Valid/ready channel interfaces for the median frame-rate regulator.
// Depends on mfrr_pkg for field widths.
`default_nettype none

interface mfrr_in_if
  import mfrr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [RATE_BITS-1:0] frames_observed;

  modport source (output valid, kind, frames_observed, input ready);
  modport sink   (input valid, kind, frames_observed, output ready);
endinterface

interface mfrr_out_if
  import mfrr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [RATE_BITS-1:0] frame_limit;
  logic [RATE_BITS-1:0] median_rate;
  logic                 median_taken;
  logic                 limit_applied;

  modport source (output valid, frame_limit, median_rate, median_taken, limit_applied,
                  input ready);
  modport sink   (input valid, frame_limit, median_rate, median_taken, limit_applied,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/median_frame_rate_regulator.sv
// Median frame-rate regulator: sample window, median by rank counting, limit stepping.
// Depends on mfrr_pkg and the channel interfaces in mfrr_if.sv.
// Sequence: a restart or a warm-up sample goes from IDLE straight to FIN; a recorded sample
// passes CHK, and when a median is taken over n held samples (n up to WINDOW_DEPTH), each
// candidate takes CAND_RD, CAND_LD, CMP over every entry and EVAL, then ADJ and FIN.
// The single compare-and-count unit walks the window memory once per candidate entry.
// One item at a time: the next input beat is taken in the cycle the result first shows, and an
// untaken result holds back the next result.
// Async active-low reset clears control state and config; the window memory is not cleared
// and needs no clearing pass.
`default_nettype none

module median_frame_rate_regulator
  import mfrr_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  mfrr_in_if.sink                  in_i,
  mfrr_out_if.source               out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [CFG_BITS-1:0] cfg_data_i
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > ACT_BITS) ? CNT_W : ACT_BITS;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);

  logic [RATE_BITS-1:0] window_mem [WINDOW_DEPTH];

  state_e               state_q, state_d;
  logic [RATE_BITS-1:0] target_q, init_q;
  logic [AGE_BITS-1:0]  warmup_q;
  logic [ACT_BITS-1:0]  act_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [SLOT_W-1:0]    oldest_q, oldest_d;
  logic [AGE_BITS-1:0]  age_q, age_d;
  logic [RATE_BITS-1:0] limit_q, limit_d;
  logic [SLOT_W-1:0]    cand_idx_q, cand_idx_d;
  logic [SLOT_W-1:0]    scan_idx_q, scan_idx_d;
  logic [RATE_BITS-1:0] cand_q, cand_d;
  logic [CNT_W-1:0]     lt_q, lt_d, le_q, le_d;
  logic [RATE_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [RATE_BITS-1:0] res_med_q, res_med_d;
  logic                 res_taken_q, res_taken_d;
  logic                 res_applied_q, res_applied_d;
  logic                 out_valid_q, out_valid_d;
  logic [RATE_BITS-1:0] out_limit_q, out_limit_d;
  logic [RATE_BITS-1:0] out_med_q, out_med_d;
  logic                 out_taken_q, out_taken_d;
  logic                 out_applied_q, out_applied_d;
  logic [RATE_BITS-1:0] rdata_q;

  logic [SLOT_W-1:0]    raddr;
  logic                 we;
  logic [SLOT_W-1:0]    waddr;
  logic                 in_fire, out_fire;
  logic [CNT_W-1:0]     rank_hi, rank_lo;
  logic [RATE_BITS:0]   med_sum;
  logic [RATE_BITS-1:0] med;
  logic [RATE_BITS-1:0] delta_up, delta_dn, step_up, step_dn;
  logic [RATE_BITS:0]   lim_up;
  logic [RATE_BITS-1:0] lim_up_sat, lim_dn, init_lim;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.frame_limit   = out_limit_q;
  assign out_o.median_rate   = out_med_q;
  assign out_o.median_taken  = out_taken_q;
  assign out_o.limit_applied = out_applied_q;

  assign rank_hi = count_q >> 1;
  assign rank_lo = count_q[0] ? rank_hi : rank_hi - CNT_W'(1);

  assign med_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign med        = med_sum[RATE_BITS:1];
  assign delta_up   = target_q - med;
  assign delta_dn   = med - target_q;
  assign step_up    = (delta_up > STEP_CAP) ? STEP_CAP :
                      ((delta_up == RATE_ONE) ? '0 : delta_up);
  assign step_dn    = (delta_dn > STEP_CAP) ? STEP_CAP : delta_dn;
  assign lim_up     = {1'b0, limit_q} + {1'b0, step_up};
  assign lim_up_sat = lim_up[RATE_BITS] ? RATE_MAX : lim_up[RATE_BITS-1:0];
  assign lim_dn     = (limit_q > step_dn) ? limit_q - step_dn : RATE_ONE;
  assign init_lim   = (init_q == '0) ? RATE_ONE : init_q;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    oldest_d      = oldest_q;
    age_d         = age_q;
    limit_d       = limit_q;
    cand_idx_d    = cand_idx_q;
    scan_idx_d    = scan_idx_q;
    cand_d        = cand_q;
    lt_d          = lt_q;
    le_d          = le_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    res_med_d     = res_med_q;
    res_taken_d   = res_taken_q;
    res_applied_d = res_applied_q;
    out_valid_d   = out_valid_q && !out_fire;
    out_limit_d   = out_limit_q;
    out_med_d     = out_med_q;
    out_taken_d   = out_taken_q;
    out_applied_d = out_applied_q;
    raddr         = cand_idx_q;
    we            = 1'b0;
    waddr         = oldest_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_med_d     = '0;
          res_taken_d   = 1'b0;
          res_applied_d = 1'b0;
          if (kind_e'(in_i.kind) == KIND_RESTART) begin
            age_d         = '0;
            count_d       = '0;
            oldest_d      = '0;
            limit_d       = init_lim;
            res_applied_d = 1'b1;
            state_d       = ST_FIN;
          end else begin
            if (age_q != AGE_MAX) begin
              age_d = age_q + AGE_BITS'(1);
            end
            if (age_q >= warmup_q) begin
              we = 1'b1;
              if (count_q == CNT_FULL) begin
                waddr    = oldest_q;
                oldest_d = (oldest_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                   : oldest_q + SLOT_W'(1);
              end else begin
                waddr   = count_q[SLOT_W-1:0];
                count_d = count_q + CNT_W'(1);
              end
              state_d = ST_CHK;
            end else begin
              state_d = ST_FIN;
            end
          end
        end
      end
      ST_CHK: begin
        cand_idx_d = '0;
        if (CMP_W'(count_q) >= CMP_W'(act_q)) begin
          state_d = ST_CAND_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_CAND_RD: begin
        raddr   = cand_idx_q;
        state_d = ST_CAND_LD;
      end
      ST_CAND_LD: begin
        cand_d     = rdata_q;
        raddr      = '0;
        scan_idx_d = '0;
        lt_d       = '0;
        le_d       = '0;
        state_d    = ST_CMP;
      end
      ST_CMP: begin
        raddr = scan_idx_q + SLOT_W'(1);
        lt_d  = lt_q + CNT_W'(rdata_q < cand_q);
        le_d  = le_q + CNT_W'(rdata_q <= cand_q);
        if (CNT_W'(scan_idx_q) == count_q - CNT_W'(1)) begin
          state_d = ST_EVAL;
        end else begin
          scan_idx_d = scan_idx_q + SLOT_W'(1);
        end
      end
      ST_EVAL: begin
        if (lt_q <= rank_lo && rank_lo < le_q) begin
          lo_d = cand_q;
        end
        if (lt_q <= rank_hi && rank_hi < le_q) begin
          hi_d = cand_q;
        end
        if (CNT_W'(cand_idx_q) == count_q - CNT_W'(1)) begin
          state_d = ST_ADJ;
        end else begin
          cand_idx_d = cand_idx_q + SLOT_W'(1);
          state_d    = ST_CAND_RD;
        end
      end
      ST_ADJ: begin
        res_med_d   = med;
        res_taken_d = 1'b1;
        if (med < target_q) begin
          limit_d       = lim_up_sat;
          count_d       = '0;
          oldest_d      = '0;
          res_applied_d = 1'b1;
        end else if (med > target_q && delta_dn != RATE_ONE) begin
          limit_d       = lim_dn;
          count_d       = '0;
          oldest_d      = '0;
          res_applied_d = 1'b1;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_limit_d   = limit_q;
          out_med_d     = res_med_q;
          out_taken_d   = res_taken_q;
          out_applied_d = res_applied_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TARGET_RST;
      warmup_q    <= WARMUP_RST;
      act_q       <= ACT_RST;
      init_q      <= INIT_RST;
      count_q     <= '0;
      oldest_q    <= '0;
      age_q       <= '0;
      limit_q     <= INIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      oldest_q    <= oldest_d;
      age_q       <= age_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_TARGET: target_q <= cfg_data_i[RATE_BITS-1:0];
          REG_WARMUP: warmup_q <= cfg_data_i[AGE_BITS-1:0];
          REG_ACT:    act_q    <= cfg_data_i[ACT_BITS-1:0];
          REG_INIT:   init_q   <= cfg_data_i[RATE_BITS-1:0];
          default:    target_q <= target_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_idx_q    <= cand_idx_d;
    scan_idx_q    <= scan_idx_d;
    cand_q        <= cand_d;
    lt_q          <= lt_d;
    le_q          <= le_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    res_med_q     <= res_med_d;
    res_taken_q   <= res_taken_d;
    res_applied_q <= res_applied_d;
    out_limit_q   <= out_limit_d;
    out_med_q     <= out_med_d;
    out_taken_q   <= out_taken_d;
    out_applied_q <= out_applied_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      window_mem[waddr] <= in_i.frames_observed;
    end
    rdata_q <= window_mem[raddr];
  end

endmodule

`default_nettype wire

>>> test/tb_median_frame_rate_regulator.sv
// Testbench for median_frame_rate_regulator: a directed table, then random phases of samples and
// restarts under many register settings, each result checked against a predictor or a typed row.
// Depends on mfrr_pkg, the channel interfaces in mfrr_if.sv and the regulator RTL.
module tb_median_frame_rate_regulator;
  timeunit 1ns;
  timeprecision 1ps;

  import mfrr_pkg::*;

  localparam int unsigned WIN_DEPTH   = 16;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 400;
  localparam int unsigned IDLE_PCT    = 6;
  localparam int unsigned DIR_ROWS    = 25;

  typedef struct packed {
    logic [RATE_BITS-1:0] frame_limit;
    logic [RATE_BITS-1:0] median_rate;
    logic                 median_taken;
    logic                 limit_applied;
  } regulation_t;

  typedef struct {
    kind_e                kind;
    logic [RATE_BITS-1:0] frames;
    bit                   typed;
    regulation_t          res;
  } vector_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_BITS-1:0] cfg_data_i;

  mfrr_in_if  in_if ();
  mfrr_out_if out_if ();

  median_frame_rate_regulator #(
    .WINDOW_DEPTH(WIN_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state and register mirror
  logic [RATE_BITS-1:0] ring_q [WIN_DEPTH];
  int unsigned          ring_cnt;
  int unsigned          ring_head;
  int unsigned          age_s;
  logic [RATE_BITS-1:0] limit_s;
  logic [RATE_BITS-1:0] target_r;
  logic [AGE_BITS-1:0]  warmup_r;
  logic [ACT_BITS-1:0]  act_r;
  logic [RATE_BITS-1:0] init_r;

  regulation_t pending_q [$];
  int unsigned err_cnt;
  int unsigned beats_in;
  int unsigned restarts_in;
  int unsigned medians_out;
  int unsigned applied_out;
  int unsigned settings_cnt;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;
  bit          no_idle;

  vector_t dir_tbl [DIR_ROWS] = '{
    '{KIND_SAMPLE,  10'd1023, 1'b1, '{10'd60, 10'd0, 1'b0, 1'b0}},
    '{KIND_SAMPLE,  10'd0,    1'b1, '{10'd60, 10'd0, 1'b0, 1'b0}},
    '{KIND_RESTART, 10'd0,    1'b1, '{10'd60, 10'd0, 1'b0, 1'b1}},
    '{KIND_SAMPLE,  10'd5,    1'b1, '{10'd60, 10'd0, 1'b0, 1'b0}},
    '{KIND_SAMPLE,  10'd1023, 1'b1, '{10'd60, 10'd0, 1'b0, 1'b0}},
    '{KIND_SAMPLE,  10'd60,   1'b0, '0},
    '{KIND_SAMPLE,  10'd61,   1'b0, '0},
    '{KIND_SAMPLE,  10'd59,   1'b0, '0},
    '{KIND_SAMPLE,  10'd1023, 1'b0, '0},
    '{KIND_SAMPLE,  10'd0,    1'b0, '0},
    '{KIND_SAMPLE,  10'd1023, 1'b0, '0},
    '{KIND_SAMPLE,  10'd62,   1'b0, '0},
    '{KIND_SAMPLE,  10'd1023, 1'b0, '0},
    '{KIND_SAMPLE,  10'd1023, 1'b0, '0},
    '{KIND_SAMPLE,  10'd50,   1'b0, '0},
    '{KIND_SAMPLE,  10'd50,   1'b0, '0},
    '{KIND_SAMPLE,  10'd50,   1'b0, '0},
    '{KIND_SAMPLE,  10'd1023, 1'b0, '0},
    '{KIND_SAMPLE,  10'd0,    1'b0, '0},
    '{KIND_SAMPLE,  10'd59,   1'b0, '0},
    '{KIND_SAMPLE,  10'd59,   1'b0, '0},
    '{KIND_SAMPLE,  10'd59,   1'b0, '0},
    '{KIND_SAMPLE,  10'd59,   1'b0, '0},
    '{KIND_SAMPLE,  10'd59,   1'b0, '0},
    '{KIND_RESTART, 10'd1023, 1'b1, '{10'd60, 10'd0, 1'b0, 1'b1}}
  };

  function automatic logic [RATE_BITS-1:0] clamp_rate(int v);
    if (v < 1) return RATE_BITS'(1);
    if (v > int'(RATE_MAX)) return RATE_MAX;
    return RATE_BITS'(v);
  endfunction

  function automatic logic [RATE_BITS-1:0] window_median();
    int unsigned vals [WIN_DEPTH];
    int unsigned key;
    int          i;
    int          j;
    for (i = 0; i < ring_cnt; i++) vals[i] = ring_q[(ring_head + i) % WIN_DEPTH];
    for (i = 1; i < ring_cnt; i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    if (ring_cnt % 2 == 0) return RATE_BITS'((vals[ring_cnt/2-1] + vals[ring_cnt/2]) / 2);
    return RATE_BITS'(vals[ring_cnt/2]);
  endfunction

  function automatic regulation_t step_regulator(kind_e kind, logic [RATE_BITS-1:0] frames);
    regulation_t res;
    int          delta;
    int          stride;
    res = '0;
    if (kind == KIND_RESTART) begin
      age_s = 0;
      ring_cnt = 0;
      ring_head = 0;
      limit_s = clamp_rate(int'(init_r));
      res.limit_applied = 1'b1;
    end else begin
      if (age_s >= warmup_r) begin
        if (ring_cnt < WIN_DEPTH) begin
          ring_q[(ring_head + ring_cnt) % WIN_DEPTH] = frames;
          ring_cnt++;
        end else begin
          ring_q[ring_head] = frames;
          ring_head = (ring_head + 1) % WIN_DEPTH;
        end
        if (ring_cnt >= act_r) begin
          res.median_rate = window_median();
          res.median_taken = 1'b1;
          if (res.median_rate < target_r) begin
            delta = int'(target_r) - int'(res.median_rate);
            stride = (delta > int'(STEP_CAP)) ? int'(STEP_CAP) : ((delta == 1) ? 0 : delta);
            limit_s = clamp_rate(int'(limit_s) + stride);
            ring_cnt = 0;
            ring_head = 0;
            res.limit_applied = 1'b1;
          end else if (res.median_rate > target_r) begin
            delta = int'(res.median_rate) - int'(target_r);
            if (delta != 1) begin
              stride = (delta > int'(STEP_CAP)) ? int'(STEP_CAP) : delta;
              limit_s = (int'(limit_s) > stride) ? clamp_rate(int'(limit_s) - stride)
                                                 : RATE_BITS'(1);
              ring_cnt = 0;
              ring_head = 0;
              res.limit_applied = 1'b1;
            end
          end
        end
      end
      if (age_s < AGE_MAX) age_s++;
    end
    res.frame_limit = limit_s;
    return res;
  endfunction

  function automatic void set_reg(cfg_reg_e idx, logic [CFG_BITS-1:0] d);
    case (idx)
      REG_TARGET: target_r = d[RATE_BITS-1:0];
      REG_WARMUP: warmup_r = d[AGE_BITS-1:0];
      REG_ACT:    act_r    = d[ACT_BITS-1:0];
      REG_INIT:   init_r   = d[RATE_BITS-1:0];
      default:    ;
    endcase
  endfunction

  function automatic logic [RATE_BITS-1:0] pick_frames(logic [RATE_BITS-1:0] tgt);
    int unsigned sel;
    int          v;
    sel = $urandom_range(9);
    if (sel < 6) v = int'(tgt) + int'($urandom_range(6)) - 3;
    else if (sel < 8) v = int'(tgt) + int'($urandom_range(40)) - 20;
    else v = int'($urandom_range(int'(RATE_MAX)));
    if (v < 0) v = 0;
    if (v > int'(RATE_MAX)) v = int'(RATE_MAX);
    return RATE_BITS'(v);
  endfunction

  task automatic drive_item(kind_e k, logic [RATE_BITS-1:0] f, bit typed, regulation_t typed_res);
    regulation_t res;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= k;
    in_if.frames_observed <= f;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    res = step_regulator(k, f);
    pending_q = {pending_q, (typed ? typed_res : res)};
    beats_in++;
    if (k == KIND_RESTART) restarts_in++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [RATE_BITS-1:0] tgt, logic [AGE_BITS-1:0] wu,
                           logic [ACT_BITS-1:0] act, logic [RATE_BITS-1:0] init);
    cfg_reg_e            idx;
    logic [CFG_BITS-1:0] vals [4];
    vals = '{CFG_BITS'(tgt), CFG_BITS'(wu), CFG_BITS'(act), CFG_BITS'(init)};
    idx = REG_TARGET;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      set_reg(idx, vals[i]);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    settings_cnt++;
  endtask

  task automatic run_phase(logic [RATE_BITS-1:0] tgt, logic [AGE_BITS-1:0] wu,
                           logic [ACT_BITS-1:0] act, logic [RATE_BITS-1:0] init,
                           int unsigned n, int unsigned restart_pct, bit hold);
    kind_e k;
    drain();
    load_regs(tgt, wu, act, init);
    if (restart_pct == 0 || $urandom_range(9) < 8)
      drive_item(KIND_RESTART, RATE_BITS'($urandom), 1'b0, '0);
    if (hold) hold_req++;
    repeat (n) begin
      k = ($urandom_range(99) < restart_pct) ? KIND_RESTART : KIND_SAMPLE;
      drive_item(k, pick_frames(tgt), 1'b0, '0);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("median_frame_rate_regulator: mismatch");
    $finish;
  end

  // result side: check each beat, then choose ready for the next edge
  initial begin
    regulation_t exp_r;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (pending_q.size() == 0) begin
          err_cnt++;
          $error("result beat with no expectation: frame_limit %0d median_rate %0d",
                 out_if.frame_limit, out_if.median_rate);
        end else begin
          exp_r = pending_q[0];
          pending_q.delete(0);
          if (out_if.frame_limit !== exp_r.frame_limit) begin
            err_cnt++;
            $error("frame_limit: expected %0d, actual %0d", exp_r.frame_limit, out_if.frame_limit);
          end
          if (out_if.median_rate !== exp_r.median_rate) begin
            err_cnt++;
            $error("median_rate: expected %0d, actual %0d", exp_r.median_rate, out_if.median_rate);
          end
          if (out_if.median_taken !== exp_r.median_taken) begin
            err_cnt++;
            $error("median_taken: expected %0d, actual %0d",
                   exp_r.median_taken, out_if.median_taken);
          end
          if (out_if.limit_applied !== exp_r.limit_applied) begin
            err_cnt++;
            $error("limit_applied: expected %0d, actual %0d",
                   exp_r.limit_applied, out_if.limit_applied);
          end
          if (out_if.median_taken === 1'b1) medians_out++;
          if (out_if.limit_applied === 1'b1) applied_out++;
        end
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_TARGET;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.kind <= KIND_SAMPLE;
    in_if.frames_observed <= '0;
    target_r = TARGET_RST;
    warmup_r = WARMUP_RST;
    act_r = ACT_RST;
    init_r = INIT_RST;
    ring_cnt = 0;
    ring_head = 0;
    age_s = 0;
    limit_s = clamp_rate(int'(INIT_RST));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i])
      drive_item(dir_tbl[i].kind, dir_tbl[i].frames, dir_tbl[i].typed, dir_tbl[i].res);

    run_phase(RATE_MAX, '0, ACT_BITS'(1), RATE_MAX, 60, 3, 1'b0);
    run_phase('0, '0, '0, '0, 60, 3, 1'b0);
    run_phase(RATE_BITS'(1), AGE_MAX, ACT_BITS'(WIN_DEPTH), RATE_BITS'(1), 300, 0, 1'b0);
    run_phase(RATE_BITS'($urandom_range(1023, 1)), '0, {ACT_BITS{1'b1}},
              RATE_BITS'($urandom_range(1023, 1)), 40, 3, 1'b0);
    for (int p = 0; p < 8; p++) begin
      no_idle = (p == 2);
      run_phase(($urandom_range(3) == 0) ? RATE_BITS'($urandom_range(1023, 1))
                                         : RATE_BITS'($urandom_range(200, 20)),
                ($urandom_range(7) == 0) ? AGE_BITS'($urandom_range(30, 8))
                                         : AGE_BITS'($urandom_range(3)),
                ($urandom_range(3) == 0) ? ACT_BITS'($urandom_range(WIN_DEPTH, 1))
                                         : ACT_BITS'($urandom_range(6, 1)),
                RATE_BITS'($urandom_range(1023, 1)), 100, 3, p == 4);
    end
    no_idle = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d input beats (%0d restarts) over %0d register settings.",
             beats_in, restarts_in, settings_cnt);
    $display("Results carried %0d medians and %0d limit updates; %0d errors.",
             medians_out, applied_out, err_cnt);
    if (err_cnt == 0) begin
      $display("median_frame_rate_regulator: match");
    end else begin
      $display("median_frame_rate_regulator: mismatch");
    end
    $finish;
  end

endmodule

>>> median_frame_rate_regulator.f
rtl/mfrr_pkg.sv
rtl/mfrr_if.sv
rtl/median_frame_rate_regulator.sv
test/tb_median_frame_rate_regulator.sv
